// ----- hdl/tccw_pkg.sv -----
package tccw_pkg;

  // Field widths of the item payloads.
  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int COLOR_W = 4;
  localparam int IN_ROW_W = 5;
  localparam int IN_COL_W = 7;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PUT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  // Character codes with a special meaning.
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'd32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;

  // One stored cell: background, foreground, character.
  typedef struct packed {
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
    logic [CHAR_W-1:0]  ch;
  } cell_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CHAR_W-1:0]   char_code;
    logic [IN_ROW_W-1:0] read_row;
    logic [IN_COL_W-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [IN_ROW_W-1:0] cursor_row;
    logic [IN_COL_W-1:0] cursor_col;
    logic [CHAR_W-1:0]   read_char;
    logic [COLOR_W-1:0]  read_fg;
    logic [COLOR_W-1:0]  read_bg;
  } out_item_t;

endpackage

// ----- hdl/tccw_cell_ram.sv -----
module tccw_cell_ram
  import tccw_pkg::*;
#(
  parameter int DEPTH = 2000,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  cell_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output cell_t             rd_data
);

  cell_t mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/text_console_cell_writer_top.sv -----
// Text console cell writer: character-cell store with cursor, scroll and clear.
// Put, newline without scroll, read and unused kinds: the item is taken in the idle state,
// and the finish step loads the result register once it is free; no new item is taken
// until then. A scrolling newline or a bottom-row wrapping put copies rows up and blanks
// the last row, and a clear blanks every cell, bound by the one-cell-per-cycle write port.
// Reset clears the cursor and sets colors to 15 on 0; the cell store is not cleared.
module text_console_cell_writer_top
  import tccw_pkg::*;
#(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W = $clog2(SCREEN_ROWS);
  localparam int COL_W = $clog2(SCREEN_COLS + 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELLS - SCREEN_COLS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_COLS);

  typedef enum logic [4:0] {
    ST_IDLE        = 5'b00001,
    ST_SCROLL      = 5'b00010,
    ST_SCROLL_LAST = 5'b00100,
    ST_BLANK       = 5'b01000,
    ST_FINISH      = 5'b10000
  } state_t;

  state_t state;
  logic [ADDR_W-1:0] cnt;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic pend_put;
  logic [CHAR_W-1:0] pend_char;
  logic read_hit;
  logic copy_vld;
  logic [ADDR_W-1:0] copy_dst;

  logic wr_en;
  logic [ADDR_W-1:0] wr_addr;
  cell_t wr_data;
  logic rd_en;
  logic [ADDR_W-1:0] rd_addr;
  cell_t rd_data;

  logic accept;
  logic is_put;
  logic is_newline;
  logic at_bottom;
  logic line_full;
  logic read_in_range;
  logic [ROW_W-1:0] put_row;
  logic [COL_W-1:0] put_col;
  logic [ADDR_W-1:0] put_addr;
  logic [ADDR_W-1:0] read_addr;
  logic out_load;
  cell_t blank_cell;

  assign in_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;

  // Decode of the incoming item against the cursor.
  assign is_put = (in_data.kind == KIND_PUT);
  assign is_newline = (in_data.char_code == NEWLINE_CHAR);
  assign at_bottom = (int'(row) == SCREEN_ROWS - 1);
  assign line_full = (int'(col) >= SCREEN_COLS);
  assign read_in_range = (int'(in_data.read_row) < SCREEN_ROWS) &&
                         (int'(in_data.read_col) < SCREEN_COLS);
  assign put_row = line_full ? row + ROW_W'(1) : row;
  assign put_col = line_full ? COL_W'(0) : col;
  assign put_addr = ADDR_W'(put_row) * ROW_STRIDE + ADDR_W'(put_col);
  assign read_addr = ADDR_W'(in_data.read_row) * ROW_STRIDE + ADDR_W'(in_data.read_col);
  assign blank_cell = '{bg: bg_color, fg: fg_color, ch: BLANK_CHAR};
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  // Write port: scroll copies first, then blanking sweeps, then a plain put.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = put_addr;
    wr_data = '{bg: bg_color, fg: fg_color, ch: in_data.char_code};
    if (copy_vld) begin
      wr_en = 1'b1;
      wr_addr = copy_dst;
      wr_data = rd_data;
    end else if (state == ST_BLANK) begin
      wr_en = 1'b1;
      wr_addr = cnt;
      wr_data = blank_cell;
      if (pend_put && (cnt == LAST_ROW_BASE)) begin
        wr_data.ch = pend_char;
      end
    end else if (accept && is_put && !is_newline && !(line_full && at_bottom)) begin
      wr_en = 1'b1;
    end
  end

  // Read port: scroll sources, or the cell of a read item.
  assign rd_en = (state == ST_SCROLL) || (accept && (in_data.kind == KIND_READ) && read_in_range);
  assign rd_addr = (state == ST_SCROLL) ? cnt : read_addr;

  tccw_cell_ram #(
    .DEPTH (CELLS),
    .ADDR_W(ADDR_W)
  ) u_cell_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Color registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= 4'd15;
      bg_color <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FG_COLOR: fg_color <= cfg_data;
        CFG_BG_COLOR: bg_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // Copy pipeline: a source read in one cycle is written one row up in the next.
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_vld <= 1'b0;
    end else begin
      copy_vld <= (state == ST_SCROLL);
    end
    copy_dst <= cnt - ROW_STRIDE;
  end

  // Sequencer and cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row <= '0;
      col <= '0;
      pend_put <= 1'b0;
      read_hit <= 1'b0;
      cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_FINISH;
            pend_put <= 1'b0;
            read_hit <= (in_data.kind == KIND_READ) && read_in_range;
            case (in_data.kind)
              KIND_PUT: begin
                if (is_newline) begin
                  col <= '0;
                  if (at_bottom) begin
                    state <= ST_SCROLL;
                    cnt <= ROW_STRIDE;
                  end else begin
                    row <= row + ROW_W'(1);
                  end
                end else if (line_full && at_bottom) begin
                  col <= COL_W'(1);
                  pend_put <= 1'b1;
                  pend_char <= in_data.char_code;
                  state <= ST_SCROLL;
                  cnt <= ROW_STRIDE;
                end else begin
                  row <= put_row;
                  col <= put_col + COL_W'(1);
                end
              end
              KIND_CLEAR: begin
                state <= ST_BLANK;
                cnt <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SCROLL: begin
          if (cnt == LAST_CELL) begin
            state <= ST_SCROLL_LAST;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        ST_SCROLL_LAST: begin
          state <= ST_BLANK;
          cnt <= LAST_ROW_BASE;
        end
        ST_BLANK: begin
          if (cnt == LAST_CELL) begin
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: holds a result while the next item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.cursor_row <= IN_ROW_W'(row);
      out_data.cursor_col <= IN_COL_W'(col);
      out_data.read_char <= read_hit ? rd_data.ch : '0;
      out_data.read_fg <= read_hit ? rd_data.fg : '0;
      out_data.read_bg <= read_hit ? rd_data.bg : '0;
    end
  end

  // The cursor stays on the screen, and one column past the end at most.
  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    (int'(row) < SCREEN_ROWS) && (int'(col) <= SCREEN_COLS))
    else $error("cursor left the screen");

  // The final copy of a scroll is always pending when the read phase ends.
  a_scroll_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCROLL_LAST) |-> copy_vld)
    else $error("scroll copy lost at end of pass");

  // A new result only appears after the finish step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result loaded outside finish step");

  // No item is taken while a screen pass runs, so no copy write overlaps an idle cycle.
  a_no_accept_in_pass: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCROLL || state == ST_BLANK) |=> !(copy_vld && state == ST_IDLE))
    else $error("copy write overlapped an idle cycle");

endmodule
